FILE: rtl/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Sizes of the cell row, operation codes and the command broadcast to cells.
// ---------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// fixed widths of the channel fields
	localparam int OP_W   = 2;
	localparam int WORD_W = 32;
	localparam int FILL_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} dq_op_t;

	typedef logic [DATA_WIDTH-1:0] dq_word_t;
	typedef logic [CNT_W-1:0]      dq_cnt_t;
	typedef logic [IDX_W-1:0]      dq_idx_t;

	// command seen by every cell in the row, already qualified by accept/full/empty
	typedef struct packed {
		logic     push_front;
		logic     push_rear;
		logic     pop_front;
		dq_cnt_t  count;
		dq_word_t word;
	} dq_cmd_t;

endpackage

FILE: rtl/dq_req_if.sv
// ---------------------------------------------------------------------------
// dq_req_if: request channel of the double-ended queue
// Valid/ready channel carrying one operation and its push word.
// ---------------------------------------------------------------------------
interface dq_req_if;
	import dq_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [WORD_W-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink   (input valid, input op, input push_value, output ready);
endinterface

FILE: rtl/dq_rsp_if.sv
// ---------------------------------------------------------------------------
// dq_rsp_if: response channel of the double-ended queue
// Valid/ready channel carrying the result of one operation.
// ---------------------------------------------------------------------------
interface dq_rsp_if;
	import dq_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] popped_value;
	logic              underflow;
	logic              overflow;
	logic [FILL_W-1:0] fill_level;
	logic              is_empty;

	modport source (output valid, output popped_value, output underflow, output overflow,
		output fill_level, output is_empty, input ready);
	modport sink   (input valid, input popped_value, input underflow, input overflow,
		input fill_level, input is_empty, output ready);
endinterface

FILE: rtl/dq_cell.sv
// ---------------------------------------------------------------------------
// dq_cell: one storage cell of the deque row
// Holds one word; shifts toward the rear on a front push, toward the front
// on a front pop, and loads the word when it is the slot just past the rear.
// ---------------------------------------------------------------------------
module dq_cell (
	input  logic             clk,
	input  dq_pkg::dq_idx_t  idx,
	input  dq_pkg::dq_cmd_t  cmd,
	input  dq_pkg::dq_word_t left_d,
	input  dq_pkg::dq_word_t right_d,
	output dq_pkg::dq_word_t data_q
);
	import dq_pkg::*;

	dq_word_t data_d;

	// next value of this cell
	always_comb begin
		data_d = data_q;
		if (cmd.push_front) begin
			data_d = left_d;
		end else if (cmd.push_rear && (cmd.count == CNT_W'(idx))) begin
			data_d = cmd.word;
		end else if (cmd.pop_front) begin
			data_d = right_d;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

FILE: rtl/dq_ctrl.sv
// ---------------------------------------------------------------------------
// dq_ctrl: fill count, cell command and result register
// Decodes each transaction against the fill count, drives the cell row and
// registers the result for the response channel.
// ---------------------------------------------------------------------------
module dq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [dq_pkg::OP_W-1:0]     req_op,
	input  logic [dq_pkg::WORD_W-1:0]   req_push_value,
	input  dq_pkg::dq_word_t            cells [dq_pkg::DEPTH],
	output dq_pkg::dq_cmd_t             cmd,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [dq_pkg::WORD_W-1:0]   rsp_popped_value,
	output logic                        rsp_underflow,
	output logic                        rsp_overflow,
	output logic [dq_pkg::FILL_W-1:0]   rsp_fill_level,
	output logic                        rsp_is_empty
);
	import dq_pkg::*;

	dq_cnt_t  count_q, count_d;
	logic     valid_q;
	logic     accept;
	logic     full, empty;
	logic     is_push, is_pop;
	dq_op_t   op;
	dq_word_t rear_word, pop_word;
	logic [WORD_W-1:0] popped_d;
	logic     under_d, over_d;

	assign op        = dq_op_t'(req_op);
	assign req_ready = !valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign is_push   = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR);
	assign is_pop    = !is_push;

	// rear word: one-hot select of the cell at count-1
	always_comb begin
		rear_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_word = rear_word
				| (cells[i] & {DATA_WIDTH{CNT_W'(i) == (count_q - CNT_W'(1))}});
		end
	end

	// cell command and next count
	always_comb begin
		cmd.push_front = accept && (op == OP_PUSH_FRONT) && !full;
		cmd.push_rear  = accept && (op == OP_PUSH_REAR)  && !full;
		cmd.pop_front  = accept && (op == OP_POP_FRONT)  && !empty;
		cmd.count      = count_q;
		cmd.word       = DATA_WIDTH'(req_push_value);
		count_d        = count_q;
		if (accept && is_push && !full) begin
			count_d = count_q + CNT_W'(1);
		end else if (accept && is_pop && !empty) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// result of this transaction
	always_comb begin
		pop_word = (op == OP_POP_FRONT) ? cells[0] : rear_word;
		popped_d = (is_pop && !empty) ? WORD_W'(pop_word) : '0;
		under_d  = is_pop && empty;
		over_d   = is_push && full;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				valid_q <= 1'b1;
			end else if (rsp_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_popped_value <= popped_d;
			rsp_underflow    <= under_d;
			rsp_overflow     <= over_d;
			rsp_fill_level   <= FILL_W'(count_d);
			rsp_is_empty     <= (count_d == '0);
		end
	end

	assign rsp_valid = valid_q;

endmodule

FILE: rtl/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue: deque of data words built as a row of shifting cells
// Front of the deque sits in cell 0; the fill count marks the rear.
// ---------------------------------------------------------------------------
// Usage:
//   req (sink):  one transaction per operation: op selects push front, push
//                rear, pop front or pop rear; push_value is the word pushed.
//   rsp (source): one transaction per request with the popped word (zero on
//                a push or underflow), underflow and overflow flags, the fill
//                level after the operation and an empty flag.
//   The result is registered at the edge that accepts the request. Throughput
//   is one operation per cycle while rsp is not stalled; the row of cells
//   shifts or loads in a single step, and the rear word is picked by a
//   one-hot select across the row.
//   A pop on an empty deque or a push on a full one leaves the contents
//   unchanged and raises the matching flag.
//   While rsp is stalled with a result pending, req.ready drops; req is
//   accepted while the result register is empty or is emptied in the same cycle.
//   Reset (arst_n low) empties the deque and clears any pending result; the
//   cell contents are not cleared and are never read before being written.
// ---------------------------------------------------------------------------
module double_ended_queue (
	input logic clk,
	input logic arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);
	import dq_pkg::*;

	dq_cmd_t  cmd;
	dq_word_t cells [DEPTH];

	// controller
	dq_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req.valid),
		.req_ready        (req.ready),
		.req_op           (req.op),
		.req_push_value   (req.push_value),
		.cells            (cells),
		.cmd              (cmd),
		.rsp_valid        (rsp.valid),
		.rsp_ready        (rsp.ready),
		.rsp_popped_value (rsp.popped_value),
		.rsp_underflow    (rsp.underflow),
		.rsp_overflow     (rsp.overflow),
		.rsp_fill_level   (rsp.fill_level),
		.rsp_is_empty     (rsp.is_empty)
	);

	// row of cells, each linked to its neighbors
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		dq_word_t left_d, right_d;

		if (g == 0) begin : g_first
			assign left_d = cmd.word;
		end else begin : g_mid_l
			assign left_d = cells[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_d = cells[g];
		end else begin : g_mid_r
			assign right_d = cells[g+1];
		end

		dq_cell u_cell (
			.clk     (clk),
			.idx     (IDX_W'(g)),
			.cmd     (cmd),
			.left_d  (left_d),
			.right_d (right_d),
			.data_q  (cells[g])
		);
	end

endmodule
